// ===== design/pbp_pkg.sv =====
// Package for the palette bit packer: shared constants, codes and types.
// No dependencies; used by every module of the block but pbp_ram.
package pbp_pkg;

    localparam int MAX_ENTRIES_DEF       = 4096;
    localparam int MAX_PALETTE_DEF       = 256;
    localparam int BLOCK_GLOBAL_BITS_DEF = 15;
    localparam int BIOME_GLOBAL_BITS_DEF = 7;
    localparam int BIOME_PALETTE_LIMIT   = 8;
    localparam int BLOCK_MIN_BITS        = 4;
    localparam int WORD_BITS             = 64;
    localparam int ID_W                  = 32;
    localparam int CNT_W                 = 13;

    // Output kinds.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_STORAGE = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Actions.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Configuration register indexes.
    localparam logic REG_BLOCK_MODE  = 1'b0;
    localparam logic REG_ENTRY_COUNT = 1'b1;

    // One queued command from the front to the back.
    typedef struct packed {
        logic        action;
        logic [31:0] global_id;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  bits_used;
        logic [8:0]  palette_size;
        logic [63:0] word;
        logic        last;
    } res_t;

endpackage

// ===== design/palette_bit_packer.sv =====
// Top level of the palette bit packer: configuration registers, front queue, back engine.
// Depends on pbp_pkg, pbp_front, pbp_back and pbp_ram.
//
// Items are handled one at a time by the back engine behind a two-entry queue. A load
// is stored directly once the container is in global mode; otherwise the palette is
// searched 16 ids per row, in a read state and a compare state per row, and stops at
// the first hit. A drain before the container is full answers with a not-ready result.
// A header counts the storage words first, one per cycle; a single-value header skips
// the count. A palette id is read from the palette RAM, and a storage word reads and
// accumulates its packed entries one at a time. A finished result waits in one output
// register until it is taken, and the engine stalls meanwhile.
module palette_bit_packer #(
    parameter int MAX_ENTRIES = pbp_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_PALETTE = pbp_pkg::MAX_PALETTE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // global_id
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // bits_used[3:0], palette_size[12:4], word[76:13], pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // last
);
    logic        mode_reg;
    logic [12:0] count_reg;
    logic        q_valid, q_pop, res_valid;
    pbp_pkg::cmd_t in_cmd, q_cmd;
    pbp_pkg::res_t res;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b1;
            count_reg <= 13'd4096;
        end else if (cfg_we) begin
            if (cfg_index == pbp_pkg::REG_BLOCK_MODE) begin
                mode_reg <= cfg_data[0];
            end else begin
                count_reg <= cfg_data;
            end
        end
    end

    assign in_cmd.action    = s_tuser;
    assign in_cmd.global_id = s_tdata;

    pbp_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
    );

    pbp_back #(
        .MAX_ENTRIES(MAX_ENTRIES), .MAX_PALETTE(MAX_PALETTE)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .block_mode(mode_reg), .entry_count(count_reg),
        .cfg_clear(cfg_we), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .res_valid(res_valid), .res_ready(m_tready), .res(res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {3'd0, res.word, res.palette_size, res.bits_used};
    assign m_tuser  = res.kind;
    assign m_tlast  = res.last;
endmodule

// ===== design/pbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/pbp_front.sv =====
// Front part: accepts input transfers and queues them for the back part.
// Depends on pbp_pkg.
module pbp_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  pbp_pkg::cmd_t in_cmd,
    output logic          q_valid,
    input  logic          q_pop,
    output pbp_pkg::cmd_t q_cmd
);
    pbp_pkg::cmd_t buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = buf_reg[rd_reg];

    // Occupancy of the two-entry queue.
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !(q_pop && q_valid)) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && q_pop && q_valid) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Queue pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop && q_valid) begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_reg] <= in_cmd;
        end
    end
endmodule

// ===== design/pbp_back.sv =====
// Back part: palette search, entry storage and the drain sequencer.
// Depends on pbp_pkg and pbp_ram.
module pbp_back #(
    parameter int MAX_ENTRIES = pbp_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_PALETTE = pbp_pkg::MAX_PALETTE_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          block_mode,
    input  logic [12:0]   entry_count,
    input  logic          cfg_clear,
    input  logic          q_valid,
    output logic          q_pop,
    input  pbp_pkg::cmd_t q_cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output pbp_pkg::res_t res
);
    localparam int BLOCK_GLOBAL_BITS = pbp_pkg::BLOCK_GLOBAL_BITS_DEF;
    localparam int BIOME_GLOBAL_BITS = pbp_pkg::BIOME_GLOBAL_BITS_DEF;
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int PW = $clog2(MAX_PALETTE);
    localparam int LANES = (MAX_PALETTE >= 32) ? 16 : 4;
    localparam int LW = $clog2(LANES);
    localparam int BDEPTH = MAX_PALETTE / LANES;
    localparam int BW = $clog2(BDEPTH);
    localparam int GW = (BLOCK_GLOBAL_BITS > BIOME_GLOBAL_BITS) ?
                        BLOCK_GLOBAL_BITS : BIOME_GLOBAL_BITS;
    localparam int SW = GW + PW;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEARCH = 4'd1;
    localparam logic [3:0] ST_STORE  = 4'd2;
    localparam logic [3:0] ST_DHEAD  = 4'd3;
    localparam logic [3:0] ST_PRD    = 4'd4;
    localparam logic [3:0] ST_PWAIT  = 4'd5;
    localparam logic [3:0] ST_SRD    = 4'd6;
    localparam logic [3:0] ST_SWAIT  = 4'd7;
    localparam logic [3:0] ST_SACC   = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;
    localparam logic [3:0] ST_SCMP   = 4'd10;

    logic [3:0]  st_reg;
    logic [8:0]  pcnt_reg;
    logic        glob_reg;
    logic [12:0] loaded_reg;
    logic [12:0] dpos_reg;
    logic [31:0] gid_reg;
    logic [8:0]  sidx_reg;
    logic        found_reg;
    logic [PW-1:0] fidx_reg;
    logic [12:0] ent_reg;
    logic [6:0]  slot_reg;
    logic [63:0] acc_reg;
    logic        ov_reg;
    pbp_pkg::res_t ob_reg;
    logic [12:0] words_reg;

    logic [12:0] n_eff;
    logic [3:0]  bits;
    logic [8:0]  pal_sz;
    logic [6:0]  per;
    logic [12:0] words;
    logic [13:0] total;
    logic        s_we;
    logic [SW-1:0] s_wdata, s_rdata;
    logic [EW-1:0] s_raddr;
    logic        hit;
    logic [PW-1:0] hit_idx;
    logic [PW-1:0] pal_raddr;
    logic [31:0] pal_rd;
    logic [12:0] maxe;
    logic [8:0]  plim;
    logic [8:0]  store_idx;
    logic        new_glob;
    logic        pal_ins;
    logic [63:0] gmask;
    logic [63:0] s_val;
    logic [31:0]   bank_rd [LANES];
    logic [BW-1:0] bank_raddr, bank_waddr;
    logic [LW-1:0] bank_wsel;

    assign maxe  = 13'(MAX_ENTRIES);
    assign n_eff = (entry_count == 13'd0) ? 13'd1 :
                   (entry_count > maxe) ? maxe : entry_count;
    assign plim  = block_mode ? 9'(MAX_PALETTE) : 9'(pbp_pkg::BIOME_PALETTE_LIMIT);

    // Chosen bits per entry from palette state.
    always_comb begin
        if (glob_reg) begin
            bits = 4'(block_mode ? BLOCK_GLOBAL_BITS : BIOME_GLOBAL_BITS);
        end else if (pcnt_reg <= 9'd1) begin
            bits = 4'd0;
        end else if (pcnt_reg <= 9'd2) begin
            bits = 4'd1;
        end else if (pcnt_reg <= 9'd4) begin
            bits = 4'd2;
        end else if (pcnt_reg <= 9'd8) begin
            bits = 4'd3;
        end else if (pcnt_reg <= 9'd16) begin
            bits = 4'd4;
        end else if (pcnt_reg <= 9'd32) begin
            bits = 4'd5;
        end else if (pcnt_reg <= 9'd64) begin
            bits = 4'd6;
        end else if (pcnt_reg <= 9'd128) begin
            bits = 4'd7;
        end else begin
            bits = 4'd8;
        end
        if (block_mode && !glob_reg && pcnt_reg > 9'd1 && bits < 4'd4) begin
            bits = 4'd4;
        end
    end

    // Entries per word by a small table; the word count is taken in the drain header.
    always_comb begin
        case (bits)
            4'd1:    per = 7'd64;
            4'd2:    per = 7'd32;
            4'd3:    per = 7'd21;
            4'd4:    per = 7'd16;
            4'd5:    per = 7'd12;
            4'd6:    per = 7'd10;
            4'd7:    per = 7'd9;
            4'd8:    per = 7'd8;
            4'd9:    per = 7'd7;
            4'd10:   per = 7'd6;
            4'd11:   per = 7'd5;
            4'd12:   per = 7'd5;
            4'd13:   per = 7'd4;
            4'd14:   per = 7'd4;
            4'd15:   per = 7'd4;
            default: per = 7'd1;
        endcase
    end

    assign words  = words_reg;
    assign pal_sz = glob_reg ? 9'd0 : pcnt_reg;
    assign total  = 14'd1 + 14'(pal_sz) + 14'(words);

    // Storage RAM: masked global id and palette index per entry.
    pbp_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_store (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (loaded_reg[EW-1:0]),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );
    assign s_raddr = ent_reg[EW-1:0];

    // Palette RAM for the drain read.
    pbp_ram #(.WIDTH(32), .DEPTH(MAX_PALETTE)) u_pal (
        .aclk  (aclk),
        .we    (pal_ins),
        .waddr (pcnt_reg[PW-1:0]),
        .wdata (gid_reg),
        .raddr (pal_raddr),
        .rdata (pal_rd)
    );
    assign pal_raddr = PW'(dpos_reg - 13'd1);

    // Banked palette copy for the search: palette entry k lives in bank k mod LANES.
    assign bank_wsel  = pcnt_reg[LW-1:0];
    assign bank_waddr = pcnt_reg[PW-1:LW];
    assign bank_raddr = sidx_reg[PW-1:LW];

    for (genvar b = 0; b < LANES; b++) begin : g_bank
        pbp_ram #(.WIDTH(32), .DEPTH(BDEPTH)) u_bank (
            .aclk  (aclk),
            .we    (pal_ins && (bank_wsel == LW'(b))),
            .waddr (bank_waddr),
            .wdata (gid_reg),
            .raddr (bank_raddr),
            .rdata (bank_rd[b])
        );
    end

    // One row of LANES compares on the registered bank outputs.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            if ((32'(sidx_reg) + 32'(l)) < 32'(pcnt_reg) && bank_rd[l] == gid_reg) begin
                hit     = 1'b1;
                hit_idx = PW'(32'(sidx_reg) + 32'(l));
            end
        end
    end

    always_comb begin
        new_glob  = 1'b0;
        store_idx = 9'(fidx_reg);
        if (!glob_reg && !found_reg) begin
            if (pcnt_reg < plim) begin
                store_idx = pcnt_reg;
            end else begin
                new_glob = 1'b1;
            end
        end
    end
    // Each entry keeps both its id and its palette index; global mode may start later.
    assign s_we    = (st_reg == ST_STORE);
    assign pal_ins = s_we && !glob_reg && !found_reg && !new_glob;
    assign s_wdata = {gid_reg[GW-1:0], store_idx[PW-1:0]};
    assign s_val   = glob_reg ? 64'(s_rdata[SW-1:PW]) : 64'(s_rdata[PW-1:0]);

    assign gmask = (64'd1 << bits) - 64'd1;

    assign q_pop     = (st_reg == ST_IDLE) && q_valid && !ov_reg;
    assign res_valid = ov_reg;
    assign res       = ob_reg;

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            pcnt_reg   <= '0;
            glob_reg   <= 1'b0;
            loaded_reg <= '0;
            dpos_reg   <= '0;
            ov_reg     <= 1'b0;
        end else begin
            if (ov_reg && res_ready) begin
                ov_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: begin
                    if (cfg_clear) begin
                        pcnt_reg   <= '0;
                        glob_reg   <= 1'b0;
                        loaded_reg <= '0;
                        dpos_reg   <= '0;
                    end else if (q_pop) begin
                        gid_reg <= q_cmd.global_id;
                        if (q_cmd.action == pbp_pkg::ACT_LOAD) begin
                            if (loaded_reg < n_eff) begin
                                sidx_reg  <= '0;
                                found_reg <= 1'b0;
                                fidx_reg  <= '0;
                                st_reg    <= glob_reg ? ST_STORE : ST_SEARCH;
                            end
                        end else if (loaded_reg < n_eff) begin
                            ob_reg <= '{kind: pbp_pkg::KIND_NONE, bits_used: 4'd0,
                                        palette_size: 9'd0, word: 64'd0, last: 1'b0};
                            ov_reg <= 1'b1;
                        end else begin
                            st_reg <= ST_DHEAD;
                        end
                    end
                end
                ST_SEARCH: begin
                    // The bank row address is taken at this edge.
                    st_reg <= ST_SCMP;
                end
                ST_SCMP: begin
                    if (hit) begin
                        found_reg <= 1'b1;
                        fidx_reg  <= hit_idx;
                        st_reg    <= ST_STORE;
                    end else if (32'(sidx_reg) + LANES >= 32'(pcnt_reg)) begin
                        st_reg <= ST_STORE;
                    end else begin
                        sidx_reg <= sidx_reg + 9'(LANES);
                        st_reg   <= ST_SEARCH;
                    end
                end
                ST_STORE: begin
                    if (!glob_reg && !found_reg) begin
                        if (new_glob) begin
                            glob_reg <= 1'b1;
                        end else begin
                            pcnt_reg <= pcnt_reg + 9'd1;
                        end
                    end
                    loaded_reg <= loaded_reg + 13'd1;
                    st_reg     <= ST_IDLE;
                end
                ST_DHEAD: begin
                    // Count words by stepping through entries, one word per cycle.
                    if (dpos_reg == 13'd0) begin
                        words_reg <= '0;
                        ent_reg   <= '0;
                        if (bits == 4'd0) begin
                            st_reg <= ST_OUT;
                        end else begin
                            st_reg <= ST_PRD;
                        end
                    end else if (dpos_reg <= 13'(pal_sz)) begin
                        st_reg <= ST_PWAIT;
                    end else begin
                        ent_reg  <= 13'((32'(dpos_reg) - 32'd1 - 32'(pal_sz)) * 32'(per));
                        slot_reg <= '0;
                        acc_reg  <= '0;
                        st_reg   <= ST_SWAIT;
                    end
                end
                ST_PRD: begin
                    if (ent_reg >= n_eff) begin
                        st_reg <= ST_OUT;
                    end else begin
                        words_reg <= words_reg + 13'd1;
                        ent_reg   <= ent_reg + 13'(per);
                    end
                end
                ST_PWAIT: begin
                    st_reg <= ST_OUT;
                end
                ST_SWAIT: begin
                    st_reg <= ST_SACC;
                end
                ST_SACC: begin
                    acc_reg <= acc_reg | ((s_val & gmask) << (7'(slot_reg) * 7'(bits)));
                    if (slot_reg + 7'd1 >= per || ent_reg + 13'd1 >= n_eff) begin
                        st_reg <= ST_OUT;
                    end else begin
                        slot_reg <= slot_reg + 7'd1;
                        ent_reg  <= ent_reg + 13'd1;
                        st_reg   <= ST_SWAIT;
                    end
                end
                ST_OUT: begin
                    if (!ov_reg) begin
                        ob_reg.bits_used    <= bits;
                        ob_reg.palette_size <= pal_sz;
                        ob_reg.last         <= (14'(dpos_reg) + 14'd1 >= total);
                        if (dpos_reg == 13'd0) begin
                            ob_reg.kind <= pbp_pkg::KIND_HEADER;
                            ob_reg.word <= '0;
                        end else if (dpos_reg <= 13'(pal_sz)) begin
                            ob_reg.kind <= pbp_pkg::KIND_PALETTE;
                            ob_reg.word <= 64'(pal_rd);
                        end else begin
                            ob_reg.kind <= pbp_pkg::KIND_STORAGE;
                            ob_reg.word <= acc_reg;
                        end
                        ov_reg <= 1'b1;
                        if (14'(dpos_reg) + 14'd1 >= total) begin
                            pcnt_reg   <= '0;
                            glob_reg   <= 1'b0;
                            loaded_reg <= '0;
                            dpos_reg   <= '0;
                        end else begin
                            dpos_reg <= dpos_reg + 13'd1;
                        end
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== design/pbp_checker.sv =====
// Port-level checker for the palette bit packer, bound to the top level.
// Depends on pbp_pkg.
module pbp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    // A waiting result transfer holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A not-ready result never marks the end of a container.
    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == pbp_pkg::KIND_NONE |-> !m_tlast && m_tdata == 80'd0)
        else $error("bad not-ready result");

    // Headers carry no word.
    a_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == pbp_pkg::KIND_HEADER |-> m_tdata[76:13] == 64'd0)
        else $error("header carries data");
endmodule

bind palette_bit_packer pbp_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

// ===== verif/palette_bit_packer_test.sv =====
// Self-checking testbench for the palette bit packer: directed table, then random containers.
// Depends on pbp_pkg and the palette_bit_packer RTL; a local model predicts the results that the rows do not give.
module palette_bit_packer_test;

    localparam int N_ENT = 4096;
    localparam int N_PAL = 256;

    // Directed table row kinds.
    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t     kind;
        logic          idx;
        logic [12:0]   data;
        logic          act;
        logic [31:0]   gid;
        bit            typed;
        pbp_pkg::res_t res;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // global_id
    logic        s_tuser;   // action
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // bits_used[3:0], palette_size[12:4], word[76:13], pad
    logic [1:0]  m_tuser;   // kind
    logic        m_tlast;   // last

    // Local model state of the container.
    logic [31:0] mdl_ids [N_ENT];
    logic [7:0]  mdl_pidx [N_ENT];
    logic [31:0] mdl_pal [N_PAL];
    int unsigned mdl_pcount, mdl_loaded, mdl_dpos;
    bit          mdl_global;
    logic        mdl_mode;
    logic [12:0] mdl_count;

    pbp_pkg::res_t pending_results [$];
    int          err_cnt;
    int          item_cnt;
    int          send_idle, recv_idle;
    bit          hold_go, hold_done;
    int          hold_left;
    logic [31:0] id_pool [$];
    row_t        rows [$];

    palette_bit_packer u_top (.*);

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Overall time limit.
    initial begin
        #60000000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic void clear_container();
        mdl_pcount = 0;
        mdl_global = 0;
        mdl_loaded = 0;
        mdl_dpos   = 0;
    endfunction

    // Models one accepted transfer; returns 1 when it causes a result.
    function automatic bit pack_predict(input logic act, input logic [31:0] gid,
                                        output pbp_pkg::res_t r, output bit done);
        int unsigned n, bits, pal, per, words, total, k, i, w;
        logic [63:0] acc, mask;
        bit found;
        n = (mdl_count == 0) ? 1 : (mdl_count > N_ENT) ? N_ENT : mdl_count;
        r = '{pbp_pkg::KIND_NONE, 4'd0, 9'd0, 64'd0, 1'b0};
        done = 0;
        if (act == pbp_pkg::ACT_LOAD) begin
            if (mdl_loaded >= n) return 0;
            mdl_ids[mdl_loaded] = gid;
            k = 0;
            if (!mdl_global) begin
                found = 0;
                for (int j = 0; j < mdl_pcount; j++) begin
                    if (!found && mdl_pal[j] == gid) begin
                        k = j;
                        found = 1;
                    end
                end
                if (!found) begin
                    if (mdl_pcount < (mdl_mode ? N_PAL : pbp_pkg::BIOME_PALETTE_LIMIT)) begin
                        k = mdl_pcount;
                        mdl_pal[k] = gid;
                        mdl_pcount++;
                    end else begin
                        mdl_global = 1;
                    end
                end
            end
            mdl_pidx[mdl_loaded] = k[7:0];
            mdl_loaded++;
            return 0;
        end
        if (mdl_loaded < n) return 1;
        // Bits per entry follow the mode's rules.
        if (mdl_global) begin
            bits = mdl_mode ? pbp_pkg::BLOCK_GLOBAL_BITS_DEF : pbp_pkg::BIOME_GLOBAL_BITS_DEF;
        end else if (mdl_pcount <= 1) begin
            bits = 0;
        end else begin
            bits = $clog2(mdl_pcount);
            if (mdl_mode && bits < pbp_pkg::BLOCK_MIN_BITS) bits = pbp_pkg::BLOCK_MIN_BITS;
        end
        pal   = mdl_global ? 0 : mdl_pcount;
        per   = bits ? pbp_pkg::WORD_BITS / bits : 1;
        words = bits ? (n + per - 1) / per : 0;
        total = 1 + pal + words;
        r.bits_used    = bits[3:0];
        r.palette_size = pal[8:0];
        if (mdl_dpos == 0) begin
            r.kind = pbp_pkg::KIND_HEADER;
        end else if (mdl_dpos <= pal) begin
            r.kind = pbp_pkg::KIND_PALETTE;
            r.word = {32'd0, mdl_pal[mdl_dpos - 1]};
        end else begin
            r.kind = pbp_pkg::KIND_STORAGE;
            w = mdl_dpos - 1 - pal;
            mask = (64'd1 << bits) - 1;
            acc = 0;
            for (int j = 0; j < per; j++) begin
                i = w * per + j;
                if (i < n) begin
                    acc |= ((mdl_global ? {32'd0, mdl_ids[i]} : {56'd0, mdl_pidx[i]}) & mask)
                           << (j * bits);
                end
            end
            r.word = acc;
        end
        r.last = (mdl_dpos + 1 >= total);
        if (r.last) begin
            clear_container();
            done = 1;
        end else begin
            mdl_dpos++;
        end
        return 1;
    endfunction

    // Offers one transfer with random idle cycles; predicts once it is accepted.
    task automatic send_item(input logic act, input logic [31:0] gid, input bit typed,
                             input pbp_pkg::res_t typed_res, output bit done);
        pbp_pkg::res_t r;
        bit   has;
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= gid;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        has = pack_predict(act, gid, r, done);
        if (has) pending_results.insert(pending_results.size(), typed ? typed_res : r);
        item_cnt++;
        if (item_cnt == 200) hold_go = 1;
        if (item_cnt < 350) begin
            send_idle = 31;
            recv_idle = 77;
        end else if (item_cnt < 700) begin
            send_idle = 77;
            recv_idle = 31;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    // Register write once the block has gone quiet.
    task automatic write_reg(input logic idx, input logic [12:0] val);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == pbp_pkg::REG_BLOCK_MODE) mdl_mode = val[0];
        else mdl_count = val;
        clear_container();
    endtask

    // One container with random content, some early drains and surplus loads.
    task automatic run_container(input int pool_n);
        bit   done;
        pbp_pkg::res_t nr;
        int   n;
        nr = '{pbp_pkg::KIND_NONE, 4'd0, 9'd0, 64'd0, 1'b0};
        id_pool.delete();
        for (int k = 0; k < pool_n; k++) id_pool.insert(id_pool.size(), $urandom());
        n = (mdl_count == 0) ? 1 : (mdl_count > N_ENT) ? N_ENT : mdl_count;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 4)
                send_item(pbp_pkg::ACT_DRAIN, $urandom(), 0, nr, done);
            send_item(pbp_pkg::ACT_LOAD, id_pool[$urandom_range(0, pool_n - 1)], 0, nr, done);
        end
        repeat ($urandom_range(0, 2)) send_item(pbp_pkg::ACT_LOAD, $urandom(), 0, nr, done);
        done = 0;
        while (!done) send_item(pbp_pkg::ACT_DRAIN, $urandom(), 0, nr, done);
        if ($urandom_range(0, 3) == 0) send_item(pbp_pkg::ACT_DRAIN, $urandom(), 0, nr, done);
    endtask

    // Result side: random back-pressure, one long hold-off, and the checks.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[76:13], 64'd0);
                end else begin
                    pbp_pkg::res_t e;
                    e = pending_results.pop_front();
                    if (m_tuser !== e.kind) report_mismatch("kind", m_tuser, e.kind);
                    if (m_tdata[3:0] !== e.bits_used)
                        report_mismatch("bits_used", m_tdata[3:0], e.bits_used);
                    if (m_tdata[12:4] !== e.palette_size)
                        report_mismatch("palette_size", m_tdata[12:4], e.palette_size);
                    if (m_tdata[76:13] !== e.word) report_mismatch("word", m_tdata[76:13], e.word);
                    if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
                end
            end
            if (hold_go && !hold_done) begin
                hold_left = 400;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // Stimulus.
    initial begin
        bit   done;
        pbp_pkg::res_t nr;
        nr = '{pbp_pkg::KIND_NONE, 4'd0, 9'd0, 64'd0, 1'b0};
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = pbp_pkg::REG_BLOCK_MODE;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = pbp_pkg::ACT_LOAD;
        s_tdata = '0;
        err_cnt = 0;
        item_cnt = 0;
        send_idle = 31;
        recv_idle = 77;
        hold_go = 0;
        hold_done = 0;
        hold_left = 0;
        mdl_mode = 1'b1;
        mdl_count = 13'd4096;
        clear_container();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows: early drain, count of zero, widest id, biome packing, surplus load.
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_DRAIN,
                                   32'h0, 1, nr});
        rows.insert(rows.size(), '{ROW_CFG, pbp_pkg::REG_ENTRY_COUNT, 13'd0, pbp_pkg::ACT_LOAD,
                                   0, 0, nr});
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_LOAD,
                                   32'hFFFF_FFFF, 0, nr});
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_DRAIN,
                                   0, 1, '{pbp_pkg::KIND_HEADER, 4'd0, 9'd1, 64'd0, 1'b0}});
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_DRAIN,
                                   0, 1, '{pbp_pkg::KIND_PALETTE, 4'd0, 9'd1,
                                          64'hFFFF_FFFF, 1'b1}});
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_DRAIN,
                                   0, 1, nr});
        rows.insert(rows.size(), '{ROW_CFG, pbp_pkg::REG_BLOCK_MODE, 13'd0, pbp_pkg::ACT_LOAD,
                                   0, 0, nr});
        rows.insert(rows.size(), '{ROW_CFG, pbp_pkg::REG_ENTRY_COUNT, 13'd3, pbp_pkg::ACT_LOAD,
                                   0, 0, nr});
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_LOAD,
                                   32'h0, 0, nr});
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_DRAIN,
                                   0, 1, nr});
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_LOAD,
                                   32'h8000_0001, 0, nr});
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_LOAD,
                                   32'h0, 0, nr});
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_LOAD,
                                   32'h5555_5555, 0, nr});
        for (int k = 0; k < 5; k++)
            rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0,
                                       pbp_pkg::ACT_DRAIN, 0, 0, nr});
        rows.insert(rows.size(), '{ROW_CFG, pbp_pkg::REG_BLOCK_MODE, 13'd1, pbp_pkg::ACT_LOAD,
                                   0, 0, nr});
        rows.insert(rows.size(), '{ROW_CFG, pbp_pkg::REG_ENTRY_COUNT, 13'd2, pbp_pkg::ACT_LOAD,
                                   0, 0, nr});
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_LOAD,
                                   32'h7, 0, nr});
        rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0, pbp_pkg::ACT_LOAD,
                                   32'hAAAA_AAAA, 0, nr});
        for (int k = 0; k < 4; k++)
            rows.insert(rows.size(), '{ROW_ITEM, pbp_pkg::REG_BLOCK_MODE, 0,
                                       pbp_pkg::ACT_DRAIN, 0, 0, nr});
        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) write_reg(rows[k].idx, rows[k].data);
            else send_item(rows[k].act, rows[k].gid, rows[k].typed, rows[k].res, done);
        end

        // Random containers: mostly small, some that overflow the palette.
        while (item_cnt < 1050) begin
            int sel;
            sel = $urandom_range(0, 9);
            write_reg(pbp_pkg::REG_BLOCK_MODE, 13'($urandom_range(0, 1)));
            if (sel == 0 && mdl_mode) begin
                write_reg(pbp_pkg::REG_ENTRY_COUNT, 13'($urandom_range(250, 300)));
                run_container($urandom_range(200, 300));
            end else begin
                write_reg(pbp_pkg::REG_ENTRY_COUNT, 13'($urandom_range(1, 64)));
                run_container(sel < 3 ? $urandom_range(1, 3) :
                              sel < 7 ? $urandom_range(2, 12) : $urandom_range(8, 40));
            end
        end

        // An over-range count acts as the full size, so a few loads leave the container open.
        write_reg(pbp_pkg::REG_ENTRY_COUNT, 13'h1FFF);
        repeat (3) send_item(pbp_pkg::ACT_LOAD, $urandom(), 0, nr, done);
        send_item(pbp_pkg::ACT_DRAIN, 32'h0, 1, nr, done);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
